>>> design/bfso_pkg.sv
// Package for the breadth-first order block: field widths, register map,
// reset values and the type passed from the bit picker. No dependencies.
`default_nettype none

package bfso_pkg;

    localparam int NODE_W      = 5;
    localparam int ROW_W       = 32;
    localparam int CNT_W       = 6;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int MAX_NODES_D = 32;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

    localparam logic REG_NODE_COUNT = 1'b0;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] index;
    } t_pick;

endpackage

`default_nettype wire

>>> design/bfs_order_adjacency_matrix.sv
// Top level of the breadth-first order block: APB register, adjacency and
// queue memories, and the walk sequencer. Depends on bfso_pkg and bfso_pick.
//
// Channel   Direction  Handshake               Payload
// request   in         start && !busy          i_mode, i_row_index, i_row_bits, i_start_node
// result    out        o_strobe (one cycle)    o_node, o_last
// config    in         psel/penable/pwrite     paddr, pwdata, prdata
//
// A row load gives no result. A search passes through S_DEQ, S_ROW and S_SCAN
// for each reached node and repeats S_SCAN for each node it adds to the queue;
// the pace is set by the registered reads of the queue and
// adjacency memories and the single bit picker. Busy falls in the cycle that
// shows the last result. Reset is synchronous and clears the control
// state and the node count to 32; the memories are not cleared. The receiver
// cannot stall the walk.
`default_nettype none

module bfs_order_adjacency_matrix
    import bfso_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_D
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_mode,
    input  wire logic [NODE_W-1:0] i_row_index,
    input  wire logic [ROW_W-1:0]  i_row_bits,
    input  wire logic [NODE_W-1:0] i_start_node,
    output logic                   o_strobe,
    output logic [NODE_W-1:0]      o_node,
    output logic                   o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LIM = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
    localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);
    localparam logic [NODE_W+1:0] DEPTH_C = (NODE_W + 2)'(MAX_NODES);

    typedef enum logic [1:0] {S_IDLE, S_DEQ, S_ROW, S_SCAN} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_node_count;
    logic [ROW_W-1:0]  r_mask;
    logic [ROW_W-1:0]  r_visited;
    logic [CNT_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_tail;
    logic [NODE_W-1:0] r_cur;
    logic [NODE_W-1:0] r_q_rd;
    logic [ROW_W-1:0]  r_adj_rd;
    logic              r_strobe;
    logic [NODE_W-1:0] r_node;
    logic              r_last;

    logic [ROW_W-1:0]  r_adj [MAX_NODES];
    logic [NODE_W-1:0] r_queue [ROW_W];

    logic              accept;
    logic              cfg_wr;
    logic [CNT_W-1:0]  n_eff;
    logic [ROW_W-1:0]  mask_eff;
    logic              start_ok;
    logic              row_ok;
    logic [NODE_W+AW-1:0] wr_ext;
    logic [NODE_W+AW-1:0] rd_ext;
    logic [AW-1:0]     adj_wr_addr;
    logic [AW-1:0]     adj_rd_addr;
    logic [ROW_W-1:0]  cand;
    t_pick             pick;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT)
                    ? {{(DATA_W - CNT_W){1'b0}}, r_node_count} : '0;

    always_comb begin
        if (r_node_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_node_count > LIM_C) begin
            n_eff = LIM_C;
        end else begin
            n_eff = r_node_count;
        end
        for (int j = 0; j < ROW_W; j++) begin
            mask_eff[j] = (CNT_W'(j) < n_eff);
        end
    end

    assign start_ok    = ({1'b0, i_start_node} < n_eff);
    assign row_ok      = ({2'b00, i_row_index} < DEPTH_C);
    assign wr_ext      = {{AW{1'b0}}, i_row_index};
    assign rd_ext      = {{AW{1'b0}}, r_q_rd};
    assign adj_wr_addr = wr_ext[AW-1:0];
    assign adj_rd_addr = rd_ext[AW-1:0];
    assign cand        = r_adj_rd & r_mask & ~r_visited;

    bfso_pick u_pick (
        .i_cand (cand),
        .o_pick (pick)
    );

    always_ff @(posedge i_clk) begin
        if (accept && i_mode == MODE_LOAD && row_ok) begin
            r_adj[adj_wr_addr] <= i_row_bits;
        end
        if (r_state == S_ROW) begin
            r_adj_rd <= r_adj[adj_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_mode == MODE_SEARCH) begin
            r_queue[0] <= i_start_node;
        end else if (r_state == S_SCAN && pick.found) begin
            r_queue[r_tail[NODE_W-1:0]] <= pick.index;
        end
        if (r_state == S_DEQ) begin
            r_q_rd <= r_queue[r_head[NODE_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (cfg_wr && paddr[2] == REG_NODE_COUNT) begin
            r_node_count <= pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_visited <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_strobe  <= 1'b0;
            r_last    <= 1'b0;
            r_node    <= '0;
            r_cur     <= '0;
            r_mask    <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_mode == MODE_SEARCH && start_ok) begin
                        r_mask    <= mask_eff;
                        r_visited <= ROW_W'(1) << i_start_node;
                        r_head    <= '0;
                        r_tail    <= CNT_W'(1);
                        r_state   <= S_DEQ;
                    end
                end
                S_DEQ: begin
                    r_head  <= r_head + CNT_W'(1);
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_cur   <= r_q_rd;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (pick.found) begin
                        r_visited[pick.index] <= 1'b1;
                        r_tail                <= r_tail + CNT_W'(1);
                    end else begin
                        r_strobe <= 1'b1;
                        r_node   <= r_cur;
                        r_last   <= (r_head == r_tail);
                        r_state  <= (r_head == r_tail) ? S_IDLE : S_DEQ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_node   = r_node;
    assign o_last   = r_last;

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("last result shown while the walk is still running");

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_head <= r_tail) && (r_tail <= CNT_W'(ROW_W)))
        else $error("queue pointers out of order");

    a_bad_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_mode == MODE_SEARCH && !start_ok |=> !busy && !o_strobe)
        else $error("out of range start node began a walk");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result shown without a running walk");

endmodule

`default_nettype wire

>>> design/bfso_pick.sv
// Lowest set bit picker shared by every neighbor step of the walk.
// Depends on bfso_pkg.
`default_nettype none

module bfso_pick
    import bfso_pkg::*;
(
    input  wire logic [ROW_W-1:0] i_cand,
    output t_pick                 o_pick
);

    always_comb begin
        o_pick.found = |i_cand;
        o_pick.index = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (i_cand[j]) begin
                o_pick.index = NODE_W'(j);
            end
        end
    end

endmodule

`default_nettype wire
